// ----- src/tgob_pkg.sv -----
// Shared types, register codes and the 5x7 font table for the text glyph page writer.
`default_nettype none

package tgob_pkg;

    // Default depth of the command queue between front and back.
    localparam int TGOB_QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_OFFSET  = 2'd1;

    // Glyph index of the blank cell; all indexes below it come from the font table.
    localparam logic [5:0] GLYPH_SPACE = 6'd40;

    // Live configuration handed to the back end.
    typedef struct packed {
        logic [6:0] dev_addr;
        logic [3:0] col_off;
    } t_cfg;

    // One drawable character as queued between front and back.
    typedef struct packed {
        logic [5:0] glyph;
        logic [7:0] page;
        logic [7:0] column;
    } t_cmd;

    // Classify a character code: bit 6 set when drawable, bits 5:0 the glyph index.
    function automatic logic [6:0] f_classify(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            return {1'b1, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd26;
            return {1'b1, d[5:0]};
        end else if (c == 8'h3A) begin
            return {1'b1, 6'd36};
        end else if (c == 8'h3B) begin
            return {1'b1, 6'd37};
        end else if (c == 8'h3C) begin
            return {1'b1, 6'd38};
        end else if (c == 8'h2E) begin
            return {1'b1, 6'd39};
        end else if (c == 8'h20) begin
            return {1'b1, GLYPH_SPACE};
        end
        return 7'd0;
    endfunction

    // Five font columns of a glyph, first column in the top byte. Blank cell reads zero.
    function automatic logic [39:0] f_glyph_row(input logic [5:0] g);
        logic [39:0] r;
        unique case (g)
            6'd0:  r = 40'h7E_11_11_11_7E;
            6'd1:  r = 40'h7F_49_49_49_36;
            6'd2:  r = 40'h3E_41_41_41_22;
            6'd3:  r = 40'h7F_41_41_22_1C;
            6'd4:  r = 40'h7F_49_49_49_41;
            6'd5:  r = 40'h7F_09_09_09_01;
            6'd6:  r = 40'h3E_41_49_49_7A;
            6'd7:  r = 40'h7F_08_08_08_7F;
            6'd8:  r = 40'h00_41_7F_41_00;
            6'd9:  r = 40'h20_40_41_3F_01;
            6'd10: r = 40'h7F_08_14_22_41;
            6'd11: r = 40'h7F_40_40_40_40;
            6'd12: r = 40'h7F_02_0C_02_7F;
            6'd13: r = 40'h7F_04_08_10_7F;
            6'd14: r = 40'h3E_41_41_41_3E;
            6'd15: r = 40'h7F_09_09_09_06;
            6'd16: r = 40'h3E_41_51_21_5E;
            6'd17: r = 40'h7F_09_19_29_46;
            6'd18: r = 40'h46_49_49_49_31;
            6'd19: r = 40'h01_01_7F_01_01;
            6'd20: r = 40'h3F_40_40_40_3F;
            6'd21: r = 40'h1F_20_40_20_1F;
            6'd22: r = 40'h3F_40_38_40_3F;
            6'd23: r = 40'h63_14_08_14_63;
            6'd24: r = 40'h07_08_70_08_07;
            6'd25: r = 40'h61_51_49_45_43;
            6'd26: r = 40'h3E_51_49_45_3E;
            6'd27: r = 40'h00_42_7F_40_00;
            6'd28: r = 40'h42_61_51_49_46;
            6'd29: r = 40'h21_41_45_4B_31;
            6'd30: r = 40'h18_14_12_7F_10;
            6'd31: r = 40'h27_45_45_45_39;
            6'd32: r = 40'h3C_4A_49_49_30;
            6'd33: r = 40'h01_71_09_05_03;
            6'd34: r = 40'h36_49_49_49_36;
            6'd35: r = 40'h06_49_49_29_1E;
            6'd36: r = 40'h00_36_36_00_00;
            6'd37: r = 40'h00_56_36_00_00;
            6'd38: r = 40'h08_14_22_41_00;
            6'd39: r = 40'h00_00_60_60_00;
            default: r = 40'h00_00_00_00_00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/tgob_front.sv -----
// Front end: accepts characters, tracks the cursor and queues drawable characters.
`default_nettype none

module tgob_front
    import tgob_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_restart,
    input  wire logic [7:0] i_start_page,
    input  wire logic [7:0] i_start_column,
    input  wire logic       i_queue_ready,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [7:0] r_page, n_page;
    logic [7:0] r_column, n_column;
    logic [7:0] page_eff, column_eff;
    logic [7:0] column_sum;
    logic [6:0] cls;
    logic       accept;

    assign o_in_ready = i_queue_ready;
    assign accept     = i_in_valid && i_queue_ready;

    assign page_eff   = i_restart ? i_start_page   : r_page;
    assign column_eff = i_restart ? i_start_column : r_column;
    assign cls        = f_classify(i_char_code);

    assign o_push       = accept && cls[6];
    assign o_cmd.glyph  = cls[5:0];
    assign o_cmd.page   = page_eff;
    assign o_cmd.column = column_eff;

    // Advance six columns; past column 127 drop to column 0 of the next page.
    assign column_sum = column_eff + 8'd6;

    always_comb begin
        n_page   = r_page;
        n_column = r_column;
        if (accept) begin
            if (column_sum[7]) begin
                n_column = 8'd0;
                n_page   = page_eff + 8'd1;
            end else begin
                n_column = column_sum[7:0];
                n_page   = page_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page   <= 8'd0;
            r_column <= 8'd0;
        end else begin
            r_page   <= n_page;
            r_column <= n_column;
        end
    end

endmodule

`default_nettype wire

// ----- src/tgob_queue.sv -----
// Short register queue of drawable characters between front and back.
`default_nettype none

module tgob_queue
    import tgob_pkg::*;
#(
    parameter int DEPTH = TGOB_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    input  wire logic i_pop,
    output logic      o_head_valid,
    output t_cmd      o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_ready      = (r_count != CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(DEPTH)) || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- src/tgob_back.sv -----
// Back end: walks one queued character through its ten bus beats into the output register.
`default_nettype none

module tgob_back
    import tgob_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_head_valid,
    input  wire t_cmd       i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [6:0]      o_target_address,
    output logic            o_txn_first,
    output logic            o_txn_last,
    output logic            o_last
);

    localparam logic [3:0] BEAT_CMD_CTRL  = 4'd0;
    localparam logic [3:0] BEAT_PAGE      = 4'd1;
    localparam logic [3:0] BEAT_COL_LO    = 4'd2;
    localparam logic [3:0] BEAT_COL_HI    = 4'd3;
    localparam logic [3:0] BEAT_DATA_CTRL = 4'd4;
    localparam logic [3:0] BEAT_GLYPH0    = 4'd5;
    localparam logic [3:0] BEAT_GLYPH1    = 4'd6;
    localparam logic [3:0] BEAT_GLYPH2    = 4'd7;
    localparam logic [3:0] BEAT_GLYPH3    = 4'd8;
    localparam logic [3:0] BEAT_LAST      = 4'd9;

    logic [3:0]  r_beat;
    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic [6:0]  r_addr;
    logic        r_first, r_txn_last, r_last;
    logic [7:0]  n_byte;
    logic        n_first, n_txn_last;
    logic [39:0] glyph_row;
    logic [4:0]  col_lo;
    logic        slot_free, fire;

    assign slot_free = !r_out_valid || i_out_ready;
    assign fire      = slot_free && i_head_valid;
    assign o_pop     = fire && (r_beat == BEAT_LAST);

    assign glyph_row = f_glyph_row(i_head.glyph);
    assign col_lo    = {1'b0, i_head.column[3:0]} + {1'b0, i_cfg.col_off};

    always_comb begin
        n_first    = 1'b0;
        n_txn_last = 1'b0;
        unique case (r_beat)
            BEAT_CMD_CTRL: begin
                n_byte  = 8'h00;
                n_first = 1'b1;
            end
            BEAT_PAGE:   n_byte = 8'hB0 | i_head.page;
            BEAT_COL_LO: n_byte = {3'b000, col_lo};
            BEAT_COL_HI: begin
                n_byte     = {4'h1, i_head.column[7:4]};
                n_txn_last = 1'b1;
            end
            BEAT_DATA_CTRL: begin
                n_byte  = 8'h40;
                n_first = 1'b1;
            end
            BEAT_GLYPH0: n_byte = glyph_row[39:32];
            BEAT_GLYPH1: n_byte = glyph_row[31:24];
            BEAT_GLYPH2: n_byte = glyph_row[23:16];
            BEAT_GLYPH3: n_byte = glyph_row[15:8];
            BEAT_LAST: begin
                n_byte     = glyph_row[7:0];
                n_txn_last = 1'b1;
            end
            default: n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat      <= BEAT_CMD_CTRL;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
            r_beat      <= (r_beat == BEAT_LAST) ? BEAT_CMD_CTRL : r_beat + 4'd1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte     <= n_byte;
            r_addr     <= i_cfg.dev_addr;
            r_first    <= n_first;
            r_txn_last <= n_txn_last;
            r_last     <= (r_beat == BEAT_LAST);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_byte;
    assign o_target_address = r_addr;
    assign o_txn_first      = r_first;
    assign o_txn_last       = r_txn_last;
    assign o_last           = r_last;

    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat <= BEAT_LAST)
        else $error("beat counter out of range");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_first |-> !r_txn_last && !r_last)
        else $error("transaction opens and closes on one beat");

    a_pop_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid && r_last && r_txn_last)
        else $error("queue entry released before its final beat");

endmodule

`default_nettype wire

// ----- src/text_glyph_to_oled_byte_stream.sv -----
// Top level of the text glyph page writer: config registers, front end, queue, back end.
`default_nettype none

// Text glyph to display page writer. Each accepted character (A-Z, 0-9, ':', ';', '<', '.',
// space) becomes ten bus beats in two write transactions: the command write 0x00, 0xB0|page,
// (column & 0x0F) + column_offset, 0x10|(column >> 4), then the data write 0x40 and five
// 5x7 font columns (all zero for space). Other codes produce no beats but still move the
// cursor, which steps six columns per character and wraps to column 0 of the next page past
// column 127; restart loads the cursor from start_page/start_column before drawing. Rate:
// the front end takes one character per cycle while the command queue (QUEUE_DEPTH entries)
// has room; the back end issues one beat per cycle while the output is ready, so a drawable
// character holds the output for all ten of its beats before another character starts.
// Characters that draw nothing are accepted but never enter the queue. With the block idle,
// an accepted character is first written into the queue and its first beat is then
// loaded into the output register. Config writes are always ready and take effect on the
// next beats issued; write them only while the block is idle.
module text_glyph_to_oled_byte_stream
    import tgob_pkg::*;
#(
    parameter int QUEUE_DEPTH = TGOB_QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // character channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [7:0]             i_char_code,
    input  wire logic                   i_restart,
    input  wire logic [7:0]             i_start_page,
    input  wire logic [7:0]             i_start_column,
    // bus byte channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [7:0]                  o_out_byte,
    output logic [6:0]                  o_target_address,
    output logic                        o_txn_first,
    output logic                        o_txn_last,
    output logic                        o_last,
    // configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, pop, queue_ready, head_valid;

    // Registers take a write on any beat; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr <= 7'd60;
            r_cfg.col_off  <= 4'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_cfg.dev_addr <= i_cfg_data[6:0];
                CFG_COLUMN_OFFSET:  r_cfg.col_off  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Front: classify and place the cursor; only drawable characters enter the queue.
    tgob_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_restart      (i_restart),
        .i_start_page   (i_start_page),
        .i_start_column (i_start_column),
        .i_queue_ready  (queue_ready),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Queue decouples character intake from beat issue.
    tgob_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_ready      (queue_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_cmd)
    );

    // Back: sequence the ten beats of the head character into the output register.
    tgob_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_head_valid     (head_valid),
        .i_head           (head_cmd),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_target_address (o_target_address),
        .o_txn_first      (o_txn_first),
        .o_txn_last       (o_txn_last),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire
